### src/tewf_pkg.sv
// shared types and codes for the trace event window filter
package tewf_pkg;

  typedef enum logic [2:0] {
    FUNC_EVENT     = 3'd0,
    FUNC_THREAD    = 3'd1,
    FUNC_PROCESS   = 3'd2,
    FUNC_CPU       = 3'd3,
    FUNC_CODE      = 3'd4,
    FUNC_TIME_WIN  = 3'd5,
    FUNC_NUM_WIN   = 3'd6,
    FUNC_CODE_WIN  = 3'd7
  } func_t;

  localparam logic [7:0] LEVEL_MAX   = 8'd255;
  localparam logic [7:0] LEVEL_RESET = 8'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] clock_req;
    logic [31:0] number;
    logic [31:0] code;
    logic [31:0] thread_id;
    logic [31:0] process_id;
    logic [15:0] cpu_id;
    logic [31:0] first_arg;
    logic [63:0] window_end;
    logic        begin_param_on;
    logic        end_param_on;
    logic [31:0] end_arg;
  } in_item_t;

  typedef struct packed {
    logic       pass;
    logic       table_full;
    logic [7:0] active_level;
  } out_item_t;

endpackage

### src/tewf_if.sv
// valid/ready channel carrying one payload
interface tewf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/trace_event_window_filter_top.sv
// Trace event filter: one transaction is accepted, then a sequencer walks the
// tables with one shared 64-bit equality comparator, one entry per cycle.
// For an event each window table is scanned twice (begin, then end) and each
// set once, every table is visited even when empty, and the level is checked
// between the begin scans and the set scans. A setup item's result is offered
// in the cycle after it is accepted. in_ready is low while an item is in work
// or its result waits to be taken, and comes back in the cycle after the
// result is taken. No clearing pass after reset.
module trace_event_window_filter_top
  import tewf_pkg::*;
#(
  parameter int SET_SLOTS    = 8,
  parameter int WINDOW_SLOTS = 4
) (
  input  logic clk,
  input  logic rst_n,
  tewf_if.sink   in_ch,
  tewf_if.source out_ch
);

  localparam int SW = $clog2(SET_SLOTS + 1);
  localparam int WW = $clog2(WINDOW_SLOTS + 1);
  localparam int IW = (SW > WW) ? SW : WW;
  localparam int SI = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;
  localparam int WI = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TB, S_NB, S_CB, S_CHK, S_THR, S_PID, S_CPU, S_CDS,
    S_TE, S_NE, S_CE, S_OUT
  } state_t;

  logic [31:0] thr_m [SET_SLOTS];
  logic [31:0] pid_m [SET_SLOTS];
  logic [15:0] cpu_m [SET_SLOTS];
  logic [31:0] cds_m [SET_SLOTS];
  logic [63:0] twb_m [WINDOW_SLOTS];
  logic [63:0] twe_m [WINDOW_SLOTS];
  logic [31:0] nwb_m [WINDOW_SLOTS];
  logic [31:0] nwe_m [WINDOW_SLOTS];
  logic [31:0] cwb_m [WINDOW_SLOTS];
  logic [31:0] cwba_m [WINDOW_SLOTS];
  logic [31:0] cwe_m [WINDOW_SLOTS];
  logic [31:0] cwea_m [WINDOW_SLOTS];
  logic [1:0]  cwf_m [WINDOW_SLOTS];

  logic [SW-1:0] thr_cnt_r, pid_cnt_r, cpu_cnt_r, cds_cnt_r;
  logic [WW-1:0] tw_cnt_r, nw_cnt_r, cw_cnt_r;
  logic [7:0]    level_r;
  state_t        state_r;
  in_item_t      item_r;
  out_item_t     res_r;
  logic [IW-1:0] idx_r;
  logic          hit_r, ok_r;

  // shared comparator operands
  logic [63:0] cmp_a, cmp_b;
  logic        cmp_en, eq;
  logic [IW-1:0] lim;
  logic [SI-1:0] si;
  logic [WI-1:0] wi;

  // outcome of a setup transaction at the accepting edge
  logic add_full, win_add;

  assign si = idx_r[SI-1:0];
  assign wi = idx_r[WI-1:0];

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    cmp_en = 1'b1;
    lim = '0;
    unique case (state_r)
      S_TB: begin
        cmp_a = {32'd0, twb_m[wi][31:0]}; cmp_b = {32'd0, item_r.clock_req[31:0]};
        lim = IW'(tw_cnt_r);
      end
      S_NB: begin
        cmp_a = {32'd0, nwb_m[wi]}; cmp_b = {32'd0, item_r.number};
        lim = IW'(nw_cnt_r);
      end
      S_CB: begin
        cmp_a = {cwb_m[wi], cwba_m[wi]};
        cmp_b = {item_r.code, cwf_m[wi][0] ? item_r.first_arg : cwba_m[wi]};
        lim = IW'(cw_cnt_r);
      end
      S_THR: begin
        cmp_a = {32'd0, thr_m[si]}; cmp_b = {32'd0, item_r.thread_id};
        lim = IW'(thr_cnt_r);
      end
      S_PID: begin
        cmp_a = {32'd0, pid_m[si]}; cmp_b = {32'd0, item_r.process_id};
        lim = IW'(pid_cnt_r);
      end
      S_CPU: begin
        cmp_a = {48'd0, cpu_m[si]}; cmp_b = {48'd0, item_r.cpu_id};
        lim = IW'(cpu_cnt_r);
      end
      S_CDS: begin
        cmp_a = {32'd0, cds_m[si]}; cmp_b = {32'd0, item_r.code};
        lim = IW'(cds_cnt_r);
      end
      S_TE: begin
        cmp_a = twe_m[wi]; cmp_b = item_r.clock_req;
        lim = IW'(tw_cnt_r);
      end
      S_NE: begin
        cmp_a = {32'd0, nwe_m[wi]}; cmp_b = {32'd0, item_r.number};
        lim = IW'(nw_cnt_r);
      end
      S_CE: begin
        cmp_a = {cwe_m[wi], cwea_m[wi]};
        cmp_b = {item_r.code, cwf_m[wi][1] ? item_r.first_arg : cwea_m[wi]};
        lim = IW'(cw_cnt_r);
      end
      default: cmp_en = 1'b0;
    endcase
    eq = (cmp_a == cmp_b);
  end

  always_comb begin
    add_full = 1'b0;
    win_add  = 1'b0;
    unique case (func_t'(in_ch.data.func))
      FUNC_THREAD:  add_full = (thr_cnt_r >= SW'(SET_SLOTS));
      FUNC_PROCESS: add_full = (pid_cnt_r >= SW'(SET_SLOTS));
      FUNC_CPU:     add_full = (cpu_cnt_r >= SW'(SET_SLOTS));
      FUNC_CODE:    add_full = (cds_cnt_r >= SW'(SET_SLOTS));
      FUNC_TIME_WIN: begin
        add_full = (tw_cnt_r >= WW'(WINDOW_SLOTS));
        win_add  = !add_full;
      end
      FUNC_NUM_WIN: begin
        add_full = (nw_cnt_r >= WW'(WINDOW_SLOTS));
        win_add  = !add_full;
      end
      FUNC_CODE_WIN: begin
        add_full = (cw_cnt_r >= WW'(WINDOW_SLOTS));
        win_add  = !add_full;
      end
      default: ;
    endcase
  end

  logic last;
  logic in_range;
  assign in_range = cmp_en && (idx_r < lim);
  assign last = (idx_r + IW'(1) >= lim);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  // table writes
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      unique case (func_t'(in_ch.data.func))
        FUNC_THREAD: if (thr_cnt_r < SW'(SET_SLOTS))
          thr_m[thr_cnt_r[SI-1:0]] <= in_ch.data.thread_id;
        FUNC_PROCESS: if (pid_cnt_r < SW'(SET_SLOTS))
          pid_m[pid_cnt_r[SI-1:0]] <= in_ch.data.process_id;
        FUNC_CPU: if (cpu_cnt_r < SW'(SET_SLOTS))
          cpu_m[cpu_cnt_r[SI-1:0]] <= in_ch.data.cpu_id;
        FUNC_CODE: if (cds_cnt_r < SW'(SET_SLOTS))
          cds_m[cds_cnt_r[SI-1:0]] <= in_ch.data.code;
        FUNC_TIME_WIN: if (tw_cnt_r < WW'(WINDOW_SLOTS)) begin
          twb_m[tw_cnt_r[WI-1:0]] <= in_ch.data.clock_req;
          twe_m[tw_cnt_r[WI-1:0]] <= in_ch.data.window_end;
        end
        FUNC_NUM_WIN: if (nw_cnt_r < WW'(WINDOW_SLOTS)) begin
          nwb_m[nw_cnt_r[WI-1:0]] <= in_ch.data.number;
          nwe_m[nw_cnt_r[WI-1:0]] <= in_ch.data.window_end[31:0];
        end
        FUNC_CODE_WIN: if (cw_cnt_r < WW'(WINDOW_SLOTS)) begin
          cwb_m[cw_cnt_r[WI-1:0]]  <= in_ch.data.code;
          cwba_m[cw_cnt_r[WI-1:0]] <= in_ch.data.first_arg;
          cwe_m[cw_cnt_r[WI-1:0]]  <= in_ch.data.window_end[31:0];
          cwea_m[cw_cnt_r[WI-1:0]] <= in_ch.data.end_arg;
          cwf_m[cw_cnt_r[WI-1:0]]  <= {in_ch.data.end_param_on, in_ch.data.begin_param_on};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      thr_cnt_r <= '0; pid_cnt_r <= '0; cpu_cnt_r <= '0; cds_cnt_r <= '0;
      tw_cnt_r  <= '0; nw_cnt_r <= '0; cw_cnt_r <= '0;
      level_r   <= LEVEL_RESET;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.data;
          idx_r  <= '0;
          res_r.pass <= 1'b0;
          res_r.table_full <= add_full;
          res_r.active_level <= win_add ? 8'd0 : level_r;
          if (win_add) level_r <= '0;
          state_r <= (func_t'(in_ch.data.func) == FUNC_EVENT) ? S_TB : S_OUT;
          if (!add_full) begin
            unique case (func_t'(in_ch.data.func))
              FUNC_THREAD:   thr_cnt_r <= thr_cnt_r + SW'(1);
              FUNC_PROCESS:  pid_cnt_r <= pid_cnt_r + SW'(1);
              FUNC_CPU:      cpu_cnt_r <= cpu_cnt_r + SW'(1);
              FUNC_CODE:     cds_cnt_r <= cds_cnt_r + SW'(1);
              FUNC_TIME_WIN: tw_cnt_r <= tw_cnt_r + WW'(1);
              FUNC_NUM_WIN:  nw_cnt_r <= nw_cnt_r + WW'(1);
              FUNC_CODE_WIN: cw_cnt_r <= cw_cnt_r + WW'(1);
              default: ;
            endcase
          end
        end
        S_TB, S_NB, S_CB: begin
          if (in_range && eq && level_r != LEVEL_MAX) level_r <= level_r + 8'd1;
          if (last) begin
            idx_r <= '0;
            priority case (state_r)
              S_TB: state_r <= S_NB;
              S_NB: state_r <= S_CB;
              default: state_r <= S_CHK;
            endcase
          end else idx_r <= idx_r + IW'(1);
        end
        S_CHK: begin
          ok_r  <= (level_r != 8'd0);
          hit_r <= 1'b0;
          idx_r <= '0;
          state_r <= S_THR;
        end
        S_THR, S_PID, S_CPU, S_CDS: begin
          // empty set always matches
          if (last) begin
            ok_r  <= ok_r && (lim == '0 || hit_r || (in_range && eq));
            hit_r <= 1'b0;
            idx_r <= '0;
            priority case (state_r)
              S_THR: state_r <= S_PID;
              S_PID: state_r <= S_CPU;
              S_CPU: state_r <= S_CDS;
              default: state_r <= S_TE;
            endcase
          end else begin
            hit_r <= hit_r || (in_range && eq);
            idx_r <= idx_r + IW'(1);
          end
        end
        S_TE, S_NE, S_CE: begin
          if (ok_r && in_range && eq && level_r != 8'd0) level_r <= level_r - 8'd1;
          if (last) begin
            idx_r <= '0;
            priority case (state_r)
              S_TE: state_r <= S_NE;
              S_NE: state_r <= S_CE;
              default: begin
                state_r <= S_OUT;
                res_r.pass <= ok_r;
                res_r.active_level <=
                  (ok_r && in_range && eq && level_r != 8'd0) ? level_r - 8'd1 : level_r;
              end
            endcase
          end else idx_r <= idx_r + IW'(1);
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
